/* rtl/core/elias_fano_encoder_macros.svh */
// Assertion macros shared by the encoder RTL.
// Relies on clk and rst being in scope where a macro is used.
`ifndef ELIAS_FANO_ENCODER_MACROS_SVH
`define ELIAS_FANO_ENCODER_MACROS_SVH

`define EFE_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("elias fano encoder: invariant violated");

`define EFE_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("elias fano encoder: implication violated");

`endif

/* rtl/core/efe_pkg.sv */
// Shared types, constants and helper functions of the Elias-Fano encoder.
// No dependencies.
package efe_pkg;

  localparam int WORD_BITS      = 64;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 2;
  localparam int UPPER_POS_BITS = 34;
  localparam int LOWER_BITS     = 56;
  localparam int OFFSET_BITS    = 38;
  localparam int WCOUNT_BITS    = 32;
  localparam int NCOUNT_BITS    = 32;
  localparam int LBITS_W        = 6;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ELEMENT_COUNT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_VALUE   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LAST_VALUE    = 2'd2;

  typedef struct packed {
    logic [WORD_BITS-1:0] sample_value;
  } sample_t;

  typedef struct packed {
    logic [UPPER_POS_BITS-1:0] upper_position;
    logic [LOWER_BITS-1:0]     lower_value;
    logic [OFFSET_BITS-1:0]    lower_bit_offset;
    logic                      word_valid;
    logic [WORD_BITS-1:0]      full_word;
    logic [WCOUNT_BITS-1:0]    word_index;
    logic                      tail_valid;
    logic [WORD_BITS-1:0]      tail_word;
    logic [LBITS_W-1:0]        lower_bit_count;
    logic                      input_error;
    logic                      run_done;
  } result_t;

  function automatic logic [LBITS_W-1:0] floor_log2(input logic [WORD_BITS-1:0] x);
    logic [LBITS_W-1:0] r;
    r = '0;
    for (int i = 1; i < WORD_BITS; i++) begin
      if (x[i]) begin
        r = LBITS_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/efe_stream_if.sv */
// Valid/ready stream channel carrying one payload per transfer.
// Payload type is set per instance; no other dependencies.
interface efe_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/elias_fano_encoder.sv */
// Elias-Fano encoder top level: run registers, settle timer and datapath.
// Depends on efe_pkg, efe_stream_if, efe_lowbits and efe_core.
//
// Usage:
//   Write element_count (index 0), first_value (1) and last_value (2) through
//   cfg_we/cfg_index/cfg_data while the block is idle, then stream the sorted
//   run on samples; every sample transfer yields exactly one result transfer.
//   The result carries the upper-bitvector position, the lower bits and their
//   stream offset, a completed 64-bit lower word when one fills, and on the
//   last element the partial tail word. Dropped items return input_error.
// Timing:
//   A sample passes through the input register, then its result is held in the output register.
//   Throughput is one item per cycle while results is ready and samples
//   is not held; the state loop (previous value, fill, counters) closes
//   within the single compute stage. The lower-bit count comes from a
//   two-stage pipeline fed by the run registers, so samples is held not
//   ready during each configuration write and while the settle timer runs.
// Reset:
//   rst clears the run state and restores element_count 1, offsets 0;
//   samples is not ready after reset until the settle timer expires.
// Backpressure:
//   A stalled result holds in the output register; one further sample may be
//   taken into the input register, then samples deasserts ready.
module elias_fano_encoder #(
  parameter int VALUE_BITS   = 64,
  parameter int MAX_LOW_BITS = 56,
  parameter int COUNT_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [efe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [efe_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  efe_stream_if.sink                           samples,
  efe_stream_if.source                         results
);
  import efe_pkg::*;

  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  logic [NCOUNT_BITS-1:0] element_count;
  logic [WORD_BITS-1:0]   first_value;
  logic [WORD_BITS-1:0]   last_value;
  logic [1:0]             settle;
  logic                   hold;
  logic [LBITS_W-1:0]     low_bits_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= NCOUNT_BITS'(1);
      first_value   <= '0;
      last_value    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ELEMENT_COUNT: element_count <= cfg_data[NCOUNT_BITS-1:0];
        CFG_FIRST_VALUE:   first_value   <= cfg_data[WORD_BITS-1:0];
        CFG_LAST_VALUE:    last_value    <= cfg_data[WORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE_CYCLES;
    end else if (cfg_we) begin
      settle <= SETTLE_CYCLES;
    end else if (settle != '0) begin
      settle <= settle - 2'd1;
    end
  end

  assign hold = cfg_we || (settle != '0);

  efe_lowbits #(
    .VALUE_BITS   (VALUE_BITS),
    .MAX_LOW_BITS (MAX_LOW_BITS)
  ) u_lowbits (
    .clk           (clk),
    .element_count (element_count),
    .first_value   (first_value),
    .last_value    (last_value),
    .low_bits      (low_bits_calc)
  );

  efe_core #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .hold          (hold),
    .element_count (element_count),
    .first_value   (first_value),
    .last_value    (last_value),
    .low_bits_calc (low_bits_calc),
    .samples       (samples),
    .results       (results)
  );

endmodule

/* rtl/core/efe_lowbits.sv */
// Two-stage pipeline computing the lower-bit count from the run registers.
// Depends on efe_pkg.
module efe_lowbits #(
  parameter int VALUE_BITS   = 64,
  parameter int MAX_LOW_BITS = 56
) (
  input  logic                                clk,
  input  logic [efe_pkg::NCOUNT_BITS-1:0]     element_count,
  input  logic [efe_pkg::WORD_BITS-1:0]       first_value,
  input  logic [efe_pkg::WORD_BITS-1:0]       last_value,
  output logic [efe_pkg::LBITS_W-1:0]         low_bits
);
  import efe_pkg::*;

  localparam logic [WORD_BITS-1:0] VALUE_MASK =
    (VALUE_BITS >= WORD_BITS) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
  localparam int CAP_I = (MAX_LOW_BITS < VALUE_BITS - 8) ? MAX_LOW_BITS : VALUE_BITS - 8;
  localparam logic [LBITS_W-1:0] CAP = LBITS_W'(CAP_I);

  logic [WORD_BITS-1:0]   lo;
  logic [WORD_BITS-1:0]   hi;
  logic [WORD_BITS-1:0]   span;
  logic [WORD_BITS-1:0]   n_ext;
  logic                   too_short;

  logic                   s_short;
  logic [WORD_BITS-1:0]   s_span;
  logic [WORD_BITS-1:0]   s_n;
  logic [LBITS_W-1:0]     s_lg_span;
  logic [LBITS_W-1:0]     s_lg_n;

  logic [LBITS_W-1:0]     cand;
  logic [WORD_BITS-1:0]   shifted;
  logic [LBITS_W-1:0]     res;

  assign lo        = first_value & VALUE_MASK;
  assign hi        = last_value & VALUE_MASK;
  assign span      = hi - lo;
  assign n_ext     = WORD_BITS'(element_count);
  assign too_short = (hi < lo) || (element_count == '0) || (span < n_ext);

  always_ff @(posedge clk) begin
    s_short   <= too_short;
    s_span    <= span;
    s_n       <= n_ext;
    s_lg_span <= floor_log2(span);
    s_lg_n    <= floor_log2(n_ext);
  end

  assign cand    = s_lg_span - s_lg_n;
  assign shifted = s_span >> cand;
  assign res     = (s_n > shifted) ? cand - LBITS_W'(1) : cand;

  always_ff @(posedge clk) begin
    if (s_short) begin
      low_bits <= '0;
    end else begin
      low_bits <= (res < CAP) ? res : CAP;
    end
  end

endmodule

/* rtl/core/efe_core.sv */
// Per-item datapath: input register, split and pack logic, result register.
// Depends on efe_pkg, efe_stream_if and the assertion macros.
`include "elias_fano_encoder_macros.svh"

module efe_core #(
  parameter int VALUE_BITS = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             hold,
  input  logic [efe_pkg::NCOUNT_BITS-1:0]  element_count,
  input  logic [efe_pkg::WORD_BITS-1:0]    first_value,
  input  logic [efe_pkg::WORD_BITS-1:0]    last_value,
  input  logic [efe_pkg::LBITS_W-1:0]      low_bits_calc,
  efe_stream_if.sink                       samples,
  efe_stream_if.source                     results
);
  import efe_pkg::*;

  localparam logic [WORD_BITS-1:0] VALUE_MASK =
    (VALUE_BITS >= WORD_BITS) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
  localparam int CMP_W = ((COUNT_BITS > NCOUNT_BITS) ? COUNT_BITS : NCOUNT_BITS) + 1;

  logic                    s1_valid;
  logic [WORD_BITS-1:0]    s1_value;
  logic                    take;
  logic                    advance;

  logic [COUNT_BITS-1:0]   items_seen;
  logic [LBITS_W-1:0]      low_bits_in_use;
  logic [WORD_BITS-1:0]    pack_word;
  logic [LBITS_W-1:0]      pack_fill;
  logic [WCOUNT_BITS-1:0]  words_emitted;
  logic [WORD_BITS-1:0]    previous_value;
  logic [OFFSET_BITS-1:0]  lower_position;

  logic                    res_valid;
  result_t                 res;
  result_t                 res_next;

  logic [WORD_BITS-1:0]    lo;
  logic [WORD_BITS-1:0]    hi;
  logic [LBITS_W-1:0]      lbits;
  logic [CMP_W-1:0]        seen_ext;
  logic [CMP_W-1:0]        n_ext;
  logic                    reject;
  logic                    last_item;
  logic [WORD_BITS-1:0]    delta;
  logic [WORD_BITS-1:0]    low;
  logic [WORD_BITS-1:0]    merged;
  logic [LBITS_W:0]        fill_sum;
  logic                    word_full;
  logic [WORD_BITS-1:0]    pack_word_next;
  logic [LBITS_W-1:0]      pack_fill_next;

  assign advance       = s1_valid && (!res_valid || results.ready);
  assign samples.ready = !hold && (!s1_valid || advance);
  assign take          = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_value <= samples.payload.sample_value & VALUE_MASK;
    end
  end

  assign lo        = first_value & VALUE_MASK;
  assign hi        = last_value & VALUE_MASK;
  assign lbits     = (items_seen == '0) ? low_bits_calc : low_bits_in_use;
  assign seen_ext  = CMP_W'(items_seen);
  assign n_ext     = CMP_W'(element_count);
  assign reject    = (seen_ext >= n_ext) || (s1_value < previous_value) ||
                     (s1_value < lo) || (s1_value > hi);
  assign last_item = (seen_ext + CMP_W'(1)) == n_ext;

  assign delta     = s1_value - lo;
  assign low       = delta & ((64'd1 << lbits) - 64'd1);
  assign merged    = pack_word | (low << pack_fill);
  assign fill_sum  = {1'b0, pack_fill} + {1'b0, lbits};
  assign word_full = fill_sum[LBITS_W];
  assign pack_word_next = word_full ? (low >> (7'd64 - {1'b0, pack_fill})) : merged;
  assign pack_fill_next = fill_sum[LBITS_W-1:0];

  always_comb begin
    res_next = '0;
    res_next.lower_bit_count = lbits;
    if (reject) begin
      res_next.input_error = 1'b1;
    end else begin
      res_next.upper_position   = UPPER_POS_BITS'(delta >> lbits) +
                                  UPPER_POS_BITS'(items_seen);
      res_next.lower_value      = low[LOWER_BITS-1:0];
      res_next.lower_bit_offset = lower_position;
      if (word_full) begin
        res_next.word_valid = 1'b1;
        res_next.full_word  = merged;
        res_next.word_index = words_emitted;
      end
      if (last_item) begin
        res_next.run_done = 1'b1;
        if (pack_fill_next != '0) begin
          res_next.tail_valid = 1'b1;
          res_next.tail_word  = pack_word_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      items_seen      <= '0;
      low_bits_in_use <= '0;
      pack_word       <= '0;
      pack_fill       <= '0;
      words_emitted   <= '0;
      previous_value  <= '0;
      lower_position  <= '0;
    end else if (advance) begin
      if (items_seen == '0) begin
        low_bits_in_use <= low_bits_calc;
      end
      if (!reject) begin
        items_seen     <= items_seen + COUNT_BITS'(1);
        pack_word      <= pack_word_next;
        pack_fill      <= pack_fill_next;
        previous_value <= s1_value;
        lower_position <= lower_position + OFFSET_BITS'(lbits);
        if (word_full) begin
          words_emitted <= words_emitted + WCOUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign results.valid   = res_valid;
  assign results.payload = res;

  `EFE_ASSERT_IMPLIES(a_drop_clean, res_valid && res.input_error, !res.word_valid && !res.tail_valid && !res.run_done && res.upper_position == '0)
  `EFE_ASSERT_IMPLIES(a_tail_on_done, res_valid && res.tail_valid, res.run_done)
  `EFE_ASSERT_IMPLIES(a_word_needs_bits, res_valid && res.word_valid, res.lower_bit_count != '0)
  `EFE_ASSERT_ALWAYS(a_fill_tracks_pos, pack_fill == lower_position[LBITS_W-1:0])

endmodule
